@@ hw/rtl/mrrc_pkg.sv @@
// Package for the Modbus RTU response checker: item structs, status codes,
// function codes and the reflected CRC-16 byte update.
// No dependencies.
`timescale 1ns / 1ps

package mrrc_pkg;

  // frame constants
  localparam int unsigned MAX_FRAME_BYTES_DEF = 256;
  localparam logic [15:0] CRC_POLY            = 16'hA001;
  localparam logic [15:0] CRC_INIT            = 16'hFFFF;
  localparam int unsigned EXC_BIT             = 7;
  localparam logic [8:0]  MIN_FRAME           = 9'd5;
  localparam logic [8:0]  POS_MAX             = 9'd511;
  localparam logic [7:0]  FUNC_RESET          = 8'd3;

  // function codes of the pending request
  localparam logic [7:0] FC_READ_COILS    = 8'd1;
  localparam logic [7:0] FC_READ_DISCRETE = 8'd2;
  localparam logic [7:0] FC_READ_HOLDING  = 8'd3;
  localparam logic [7:0] FC_READ_INPUT    = 8'd4;

  // frame status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_CRC   = 2'd1;
  localparam logic [1:0] ST_EXC   = 2'd2;
  localparam logic [1:0] ST_SHORT = 2'd3;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_last;
  } in_item_t;

  typedef struct packed {
    logic [15:0] data_value;
    logic [7:0]  value_index;
    logic [1:0]  frame_status;
    logic [7:0]  exc_code;
    logic        frame_end;
  } out_item_t;

  // one byte through the reflected crc-16, lsb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/modbus_rtu_response_checker.sv @@
// Top level of the Modbus RTU response checker: input register, frame state,
// crc check and value extraction, result register. Depends on mrrc_pkg.
`timescale 1ns / 1ps

//  channel   ports                            payload
//  input     in_valid / in_ready / in_item    in_item_t (rx_byte, frame_last)
//  result    out_valid / out_ready / out_item out_item_t (value, index, status)
//  config    cfg_wr_en / cfg_wr_data          request function code, 8 bits
//
// An item is taken into the input register, passes the crc update and frame
// logic and, if it yields a result, lands in the result register. One item per
// cycle is sustained unless the result stalls; one-byte crc sets the cycle path.
// rst_n is synchronous; it clears the frame state and sets the function to 3.
// A stalled result holds the input register; the input register takes an
// item when it is empty or when its content moves on in the same cycle.
module modbus_rtu_response_checker #(
  parameter int unsigned MAX_FRAME_BYTES = mrrc_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mrrc_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output mrrc_pkg::out_item_t out_item,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data
);
  import mrrc_pkg::*;

  localparam logic [9:0] MAX_POS = 10'(MAX_FRAME_BYTES);

  // registers
  logic        s1_valid_r;
  in_item_t    s1_item_r;
  logic        out_valid_r;
  out_item_t   out_item_r;
  logic [7:0]  func_r;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  older_r, older_nxt;
  logic [7:0]  newer_r, newer_nxt;
  logic [8:0]  pos_r, pos_nxt;
  logic [7:0]  count_r, count_nxt;
  logic        exc_r, exc_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic [7:0]  emitted_r, emitted_nxt;

  logic        out_free;
  logic        s1_go;
  logic        emit;
  out_item_t   res;
  logic        regs_mode;
  logic        coil_mode;
  logic [8:0]  k;
  logic [15:0] rx_crc;

  // handshake: the result register frees when empty or taken
  assign out_free  = !out_valid_r || out_ready;
  assign s1_go     = s1_valid_r && out_free;
  assign in_ready  = !s1_valid_r || out_free;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign regs_mode = (func_r == FC_READ_HOLDING) || (func_r == FC_READ_INPUT);
  assign coil_mode = (func_r == FC_READ_COILS) || (func_r == FC_READ_DISCRETE);
  assign k         = pos_r - 9'd3;

  // frame logic for the item in the input register
  always_comb begin
    crc_nxt     = (pos_r >= 9'd2) ? crc_byte(crc_r, older_r) : crc_r;
    exc_nxt     = (pos_r == 9'd1) ? s1_item_r.rx_byte[EXC_BIT] : exc_r;
    count_nxt   = (pos_r == 9'd2) ? s1_item_r.rx_byte : count_r;
    hold_nxt    = hold_r;
    emitted_nxt = emitted_r;
    older_nxt   = newer_r;
    newer_nxt   = s1_item_r.rx_byte;
    pos_nxt     = (pos_r < POS_MAX) ? pos_r + 9'd1 : pos_r;
    rx_crc      = {s1_item_r.rx_byte, newer_r};
    res         = '0;
    emit        = 1'b0;
    if (s1_item_r.frame_last) begin
      // closing status, then a fresh frame
      emit          = 1'b1;
      res.frame_end = 1'b1;
      if ({1'b0, pos_r} + 10'd1 < {1'b0, MIN_FRAME}) begin
        res.frame_status = ST_SHORT;
      end else if (rx_crc != crc_nxt) begin
        res.frame_status = ST_CRC;
      end else if (exc_nxt) begin
        res.frame_status = ST_EXC;
        res.exc_code     = count_nxt;
      end else begin
        res.frame_status = ST_OK;
      end
      crc_nxt     = CRC_INIT;
      exc_nxt     = 1'b0;
      count_nxt   = '0;
      hold_nxt    = '0;
      emitted_nxt = '0;
      older_nxt   = '0;
      newer_nxt   = '0;
      pos_nxt     = '0;
    end else if (pos_r >= 9'd3 && {1'b0, pos_r} < MAX_POS && !exc_r
                 && k < {1'b0, count_r}) begin
      // tentative data value
      if (regs_mode) begin
        if (!k[0]) begin
          hold_nxt = s1_item_r.rx_byte;
        end else begin
          emit            = 1'b1;
          res.data_value  = {hold_r, s1_item_r.rx_byte};
          res.value_index = emitted_r;
          emitted_nxt     = emitted_r + 8'd1;
        end
      end else if (coil_mode) begin
        emit            = 1'b1;
        res.data_value  = {8'h00, s1_item_r.rx_byte};
        res.value_index = emitted_r;
        emitted_nxt     = emitted_r + 8'd1;
      end
    end
  end

  // control and frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      func_r      <= FUNC_RESET;
      crc_r       <= CRC_INIT;
      older_r     <= '0;
      newer_r     <= '0;
      pos_r       <= '0;
      count_r     <= '0;
      exc_r       <= 1'b0;
      hold_r      <= '0;
      emitted_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        func_r <= cfg_wr_data;
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= s1_go && emit;
      end
      if (s1_go) begin
        crc_r     <= crc_nxt;
        older_r   <= older_nxt;
        newer_r   <= newer_nxt;
        pos_r     <= pos_nxt;
        count_r   <= count_nxt;
        exc_r     <= exc_nxt;
        hold_r    <= hold_nxt;
        emitted_r <= emitted_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_item;
    end
    if (s1_go && emit) begin
      out_item_r <= res;
    end
  end

endmodule
